### rtl/tqpa_pkg.sv
// Shared types, constants and helper functions for the transfer queue policy arbiter.
// Used by tqpa_ctrl, tqpa_datapath and the top level transfer_queue_policy_arbiter.
// No dependencies.
package tqpa_pkg;

	// Queue geometry and derived widths.
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TREE_N      = 1 << IDX_W;

	// Fixed field widths.
	localparam int INST_W   = 16;
	localparam int PRI_W    = 8;
	localparam int TIME_W   = 32;
	localparam int GIDX_W   = 4;
	localparam int QLEN_W   = 5;
	localparam int STAT_W   = 2;
	localparam int GCNT_W   = 32;
	localparam int LSUM_W   = 40;
	localparam int WSUM_W   = 48;
	localparam int LFSR_W   = 16;
	localparam int POL_W    = 2;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	// Remainder unit: bits of the LFSR word consumed per cycle.
	localparam int DIV_BITS   = 4;
	localparam int DIV_STEPS  = LFSR_W / DIV_BITS;
	localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	// Command codes.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_ARB    = 1'b1;

	// Arbitration policies.
	localparam logic [POL_W-1:0] POL_OLDEST   = 2'd0;
	localparam logic [POL_W-1:0] POL_NEWEST   = 2'd1;
	localparam logic [POL_W-1:0] POL_PRIORITY = 2'd2;
	localparam logic [POL_W-1:0] POL_RANDOM   = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 1'b1;

	// Request transaction.
	typedef struct packed {
		logic              cmd;
		logic [INST_W-1:0] inst_id;
		logic [PRI_W-1:0]  priority_req;
		logic [TIME_W-1:0] issue_time;
		logic [TIME_W-1:0] cur_time;
	} req_t;

	// Response transaction.
	typedef struct packed {
		logic              grant_valid;
		logic [INST_W-1:0] granted_inst;
		logic [GIDX_W-1:0] granted_index;
		logic [TIME_W-1:0] wait_ticks;
		logic [QLEN_W-1:0] queue_length;
		logic [STAT_W-1:0] status;
		logic [GCNT_W-1:0] arbitration_count;
		logic [LSUM_W-1:0] length_sum;
		logic [WSUM_W-1:0] wait_sum;
	} rsp_t;

	// One queue entry.
	typedef struct packed {
		logic [INST_W-1:0] inst;
		logic [PRI_W-1:0]  pri;
		logic [TIME_W-1:0] issue;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic pick;
		logic div_step;
		logic exec;
		logic done;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             empty;
		logic [POL_W-1:0] policy;
		logic             div_last;
		logic             rsp_full;
	} dp_stat_t;

	// One step of the Galois LFSR.
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

	// A zero seed would lock the LFSR, so it is replaced by one.
	function automatic logic [LFSR_W-1:0] seed_fix(input logic [LFSR_W-1:0] s);
		return (s == '0) ? LFSR_W'(1) : s;
	endfunction

endpackage

### rtl/tqpa_ctrl.sv
// Controller state machine of the transfer queue policy arbiter.
// Sequences accept, priority pick, remainder steps, execute and result load.
// Depends on tqpa_pkg.
module tqpa_ctrl import tqpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  logic     req_cmd,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PICK,
		S_DIV,
		S_EXEC,
		S_DONE
	} state_t;

	state_t state_q;
	state_t after_accept;
	logic   slot_free;

	// The result register can take a new transaction when empty or being drained.
	assign slot_free = !stat.rsp_full || rsp_ready;

	// Commands decoded from the state.
	always_comb begin
		ctl          = '0;
		ctl.done     = (state_q == S_DONE) && slot_free;
		req_ready    = (state_q == S_IDLE) || ctl.done;
		ctl.accept   = req_valid && req_ready;
		ctl.pick     = (state_q == S_PICK);
		ctl.div_step = (state_q == S_DIV);
		ctl.exec     = (state_q == S_EXEC);
	end

	// Where an accepted transaction goes first.
	always_comb begin
		after_accept = S_EXEC;
		if (req_cmd == CMD_ARB && !stat.empty) begin
			unique case (stat.policy)
				POL_PRIORITY: after_accept = S_PICK;
				POL_RANDOM:   after_accept = S_DIV;
				default:      after_accept = S_EXEC;
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.accept) begin
						state_q <= after_accept;
					end
				end
				S_PICK: begin
					state_q <= S_EXEC;
				end
				S_DIV: begin
					if (stat.div_last) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ctl.accept) begin
						state_q <= after_accept;
					end else if (ctl.done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/tqpa_datapath.sv
// Datapath of the transfer queue policy arbiter: queue registers, priority tree,
// LFSR remainder unit, grant and compaction, running totals and result register.
// Depends on tqpa_pkg.
module tqpa_datapath import tqpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             ctl,
	output dp_stat_t             stat,
	input  req_t                 req,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output rsp_t                 rsp,
	output logic                 rsp_valid,
	input  logic                 rsp_ready
);

	// Architectural state.
	entry_t            ent_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [POL_W-1:0]  policy_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [GCNT_W-1:0] grants_q;
	logic [LSUM_W-1:0] lengths_q;
	logic [WSUM_W-1:0] waits_q;

	// Working registers for the transaction in flight.
	req_t                 req_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     rem_q;
	logic [LFSR_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 g_valid_q;
	logic [INST_W-1:0]    g_inst_q;
	logic [IDX_W-1:0]     g_idx_q;
	logic [TIME_W-1:0]    g_wait_q;
	logic [CNT_W-1:0]     g_len_q;
	logic [STAT_W-1:0]    g_status_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic              full;
	logic              empty;
	logic              rand_start;
	logic [CNT_W-1:0]  count_m1;
	logic [LFSR_W-1:0] lfsr_adv;
	entry_t            sel_ent;
	entry_t            new_ent;
	logic [TIME_W-1:0] wait_c;
	logic [IDX_W-1:0]  pick_idx;
	logic [CNT_W-1:0]  rem_c;
	logic [GCNT_W-1:0] grants_n;
	logic [LSUM_W-1:0] lengths_n;
	logic [WSUM_W-1:0] waits_n;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty      = (count_q == '0);
	assign count_m1   = count_q - CNT_W'(1);
	assign lfsr_adv   = lfsr_next(lfsr_q);
	assign rand_start = ctl.accept && req.cmd == CMD_ARB && !empty && policy_q == POL_RANDOM;

	assign stat.empty    = empty;
	assign stat.policy   = policy_q;
	assign stat.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign stat.rsp_full = rsp_valid_q;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// Selected entry and its clamped wait.
	assign sel_ent = ent_q[idx_q];
	assign wait_c  = (req_q.cur_time > sel_ent.issue) ? (req_q.cur_time - sel_ent.issue) : '0;

	assign new_ent.inst  = req_q.inst_id;
	assign new_ent.pri   = req_q.priority_req;
	assign new_ent.issue = req_q.issue_time;

	// Priority tree: a valid entry always beats an empty slot, ties go to the lower index.
	always_comb begin
		logic [PRI_W:0]   node_key [2*TREE_N];
		logic [IDX_W-1:0] node_idx [2*TREE_N];
		for (int n = 0; n < 2*TREE_N; n++) begin
			node_key[n] = '0;
			node_idx[n] = '0;
		end
		for (int i = 0; i < TREE_N; i++) begin
			node_idx[TREE_N + i] = IDX_W'(i);
		end
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (CNT_W'(i) < count_q) begin
				node_key[TREE_N + i] = {1'b1, ent_q[i].pri};
			end
		end
		for (int n = TREE_N - 1; n >= 1; n--) begin
			if (node_key[2*n] >= node_key[2*n + 1]) begin
				node_key[n] = node_key[2*n];
				node_idx[n] = node_idx[2*n];
			end else begin
				node_key[n] = node_key[2*n + 1];
				node_idx[n] = node_idx[2*n + 1];
			end
		end
		pick_idx = node_idx[1];
	end

	// Restoring remainder of the LFSR word by the queue length, a few bits per cycle.
	always_comb begin
		logic [CNT_W:0] trial;
		rem_c = rem_q;
		for (int b = 0; b < DIV_BITS; b++) begin
			trial = {rem_c, quo_q[LFSR_W - 1 - b]};
			if (trial >= {1'b0, count_q}) begin
				trial = trial - {1'b0, count_q};
			end
			rem_c = trial[CNT_W-1:0];
		end
	end

	// Updated totals for the result being loaded.
	assign grants_n  = grants_q + GCNT_W'(g_valid_q);
	assign lengths_n = lengths_q + LSUM_W'(g_len_q);
	assign waits_n   = waits_q + WSUM_W'(g_wait_q);

	// Configuration, LFSR, queue count, totals and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POL_OLDEST;
			lfsr_q      <= LFSR_W'(1);
			count_q     <= '0;
			grants_q    <= '0;
			lengths_q   <= '0;
			waits_q     <= '0;
			div_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rand_start) begin
				lfsr_q    <= lfsr_adv;
				div_cnt_q <= '0;
			end else if (ctl.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (ctl.exec) begin
				if (req_q.cmd == CMD_INSERT) begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end else if (!empty) begin
					count_q <= count_m1;
				end
			end
			if (ctl.done) begin
				grants_q    <= grants_n;
				lengths_q   <= lengths_n;
				waits_q     <= waits_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POLICY: policy_q <= cfg_data[POL_W-1:0];
					CFG_SEED:   lfsr_q   <= seed_fix(cfg_data[LFSR_W-1:0]);
					default:    ;
				endcase
			end
		end
	end

	// Working registers and the result register.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			req_q <= req;
			idx_q <= (policy_q == POL_NEWEST) ? count_m1[IDX_W-1:0] : '0;
		end else if (ctl.pick) begin
			idx_q <= pick_idx;
		end else if (ctl.div_step && stat.div_last) begin
			idx_q <= rem_c[IDX_W-1:0];
		end
		if (rand_start) begin
			quo_q <= lfsr_adv;
			rem_q <= '0;
		end else if (ctl.div_step) begin
			quo_q <= quo_q << DIV_BITS;
			rem_q <= rem_c;
		end
		if (ctl.exec) begin
			g_valid_q  <= 1'b0;
			g_inst_q   <= '0;
			g_idx_q    <= '0;
			g_wait_q   <= '0;
			g_len_q    <= '0;
			g_status_q <= ST_OK;
			if (req_q.cmd == CMD_INSERT) begin
				if (full) begin
					g_status_q <= ST_FULL;
				end
			end else if (empty) begin
				g_status_q <= ST_EMPTY;
			end else begin
				g_valid_q <= 1'b1;
				g_inst_q  <= sel_ent.inst;
				g_idx_q   <= idx_q;
				g_wait_q  <= wait_c;
				g_len_q   <= count_q;
			end
		end
		if (ctl.done) begin
			rsp_q.grant_valid       <= g_valid_q;
			rsp_q.granted_inst      <= g_inst_q;
			rsp_q.granted_index     <= GIDX_W'(g_idx_q);
			rsp_q.wait_ticks        <= g_wait_q;
			rsp_q.queue_length      <= QLEN_W'(count_q);
			rsp_q.status            <= g_status_q;
			rsp_q.arbitration_count <= grants_n;
			rsp_q.length_sum        <= lengths_n;
			rsp_q.wait_sum          <= waits_n;
		end
	end

	// Queue storage: append at the tail, or close the gap behind the granted entry.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (req_q.cmd == CMD_INSERT) begin
				if (!full) begin
					for (int i = 0; i < QUEUE_DEPTH; i++) begin
						if (count_q == CNT_W'(i)) begin
							ent_q[i] <= new_ent;
						end
					end
				end
			end else if (!empty) begin
				for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
					if (IDX_W'(i) >= idx_q) begin
						ent_q[i] <= ent_q[i + 1];
					end
				end
			end
		end
	end

endmodule

### rtl/transfer_queue_policy_arbiter.sv
// Top level of the transfer queue policy arbiter.
// Instantiates tqpa_ctrl and tqpa_datapath; depends on tqpa_pkg.
//
// Usage: request transactions arrive on req with req_valid/req_ready; each one
// is an insert (append to the queue) or an arbitrate (pick one entry by the
// configured policy, remove it and report its wait). Every request produces
// exactly one response transaction on rsp with rsp_valid/rsp_ready, in order.
// Registers are written through cfg_we/cfg_index/cfg_data: index 0 selects the
// policy, index 1 loads the LFSR seed. The user must write registers only while
// the block is idle; the block itself has no check for it. After acceptance,
// inserts, oldest- and newest-first grants and empty-queue arbitrates pass
// through the execute and result-load states; a priority grant first passes the
// pick state (the priority compare tree), a random grant the remainder steps
// (four bits of the LFSR word per cycle). One request is in flight at a time;
// a new one is accepted in the cycle its predecessor's response is loaded.
// A response waits in an output register; while it waits the next request is
// still accepted and processed, and only its own response load stalls.
// Reset empties the queue, clears the totals, selects oldest first and seeds
// the LFSR with 1.
module transfer_queue_policy_arbiter import tqpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	tqpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_cmd   (req.cmd),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	tqpa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

	// Loading a result always leaves a valid response behind.
	a_done_fills: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |=> rsp_valid)
		else $error("result load did not produce a valid response");

	// A grant never carries an error status.
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.grant_valid |-> rsp.status == ST_OK)
		else $error("granted response with error status");

	// The reported queue length never exceeds the queue depth.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.queue_length <= QLEN_W'(QUEUE_DEPTH))
		else $error("queue length beyond depth");

	// Pick, remainder step, execute and result load are mutually exclusive.
	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.pick, ctl.div_step, ctl.exec, ctl.done}))
		else $error("more than one datapath phase active");

endmodule

### tb/tb.sv
// Self-checking testbench for transfer_queue_policy_arbiter.
// Drives request transactions, predicts each response with a shadow queue and
// compares them field by field; depends on tqpa_pkg and the RTL only.
module tb;
	import tqpa_pkg::*;

	localparam int LIMIT       = 1_000_000;
	localparam int SETTLE      = 12;
	localparam int HOLD_CYCLES = 300;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Shadow copy of the block state, updated once per accepted transaction and on each register write.
	entry_t              shadow_q [QUEUE_DEPTH];
	int unsigned         shadow_count  = 0;
	logic [POL_W-1:0]    shadow_policy = POL_OLDEST;
	logic [LFSR_W-1:0]   shadow_lfsr   = 16'd1;
	logic [GCNT_W-1:0]   grant_cnt     = '0;
	logic [LSUM_W-1:0]   len_total     = '0;
	logic [WSUM_W-1:0]   wait_total    = '0;

	rsp_t        due_responses[$];
	int          err_count     = 0;
	int          cycle_cnt     = 0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	logic        hold_tog      = 1'b0;
	logic        hold_seen     = 1'b0;
	int          hold_left     = 0;
	logic [31:0] sim_tick      = '0;

	transfer_queue_policy_arbiter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow state and return the response it must produce.
	function automatic rsp_t compute_response(req_t r);
		rsp_t        o;
		entry_t      e;
		int unsigned len;
		int unsigned idx;
		int unsigned i;
		o = '0;
		if (r.cmd == CMD_INSERT) begin
			if (shadow_count >= QUEUE_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				shadow_q[shadow_count] = '{inst: r.inst_id, pri: r.priority_req,
					issue: r.issue_time};
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			o.status = ST_EMPTY;
		end else begin
			len = shadow_count;
			case (shadow_policy)
				POL_OLDEST: begin
					idx = 0;
				end
				POL_NEWEST: begin
					idx = len - 1;
				end
				POL_PRIORITY: begin
					// Strict compare keeps the earliest of equal priorities.
					idx = 0;
					for (i = 1; i < len; i++) begin
						if (shadow_q[i].pri > shadow_q[idx].pri) begin
							idx = i;
						end
					end
				end
				default: begin
					// Galois shift right, taps folded in when a one falls out.
					shadow_lfsr = (shadow_lfsr >> 1) ^ (shadow_lfsr[0] ? LFSR_TAPS : '0);
					idx = shadow_lfsr % len;
				end
			endcase
			e = shadow_q[idx];
			o.grant_valid   = 1'b1;
			o.granted_inst  = e.inst;
			o.granted_index = GIDX_W'(idx);
			o.wait_ticks    = (r.cur_time > e.issue) ? r.cur_time - e.issue : '0;
			for (i = idx; i + 1 < len; i++) begin
				shadow_q[i] = shadow_q[i + 1];
			end
			shadow_count = len - 1;
			grant_cnt  = grant_cnt + 1'b1;
			len_total  = len_total + LSUM_W'(len);
			wait_total = wait_total + WSUM_W'(o.wait_ticks);
		end
		o.queue_length      = QLEN_W'(shadow_count);
		o.arbitration_count = grant_cnt;
		o.length_sum        = len_total;
		o.wait_sum          = wait_total;
		return o;
	endfunction

	function automatic void compare_field(string fname, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= 10) begin
				$display("tb: %s mismatch, expected %0h, got %0h", fname, want, got);
			end
		end
	endfunction

	// Check every response transaction against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (due_responses.size() == 0) begin
				err_count++;
				if (err_count <= 10) begin
					$display("tb: response with none expected, got %h", rsp);
				end
			end else begin
				want = due_responses.pop_front();
				compare_field("grant_valid", want.grant_valid, rsp.grant_valid);
				compare_field("granted_inst", want.granted_inst, rsp.granted_inst);
				compare_field("granted_index", want.granted_index, rsp.granted_index);
				compare_field("wait_ticks", want.wait_ticks, rsp.wait_ticks);
				compare_field("queue_length", want.queue_length, rsp.queue_length);
				compare_field("status", want.status, rsp.status);
				compare_field("arbitration_count", want.arbitration_count,
					rsp.arbitration_count);
				compare_field("length_sum", want.length_sum, rsp.length_sum);
				compare_field("wait_sum", want.wait_sum, rsp.wait_sum);
			end
		end
	end

	// Response side: random stalls, plus a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_tog != hold_seen) begin
				hold_seen = hold_tog;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Offer one request transaction, after a random gap, and predict its response.
	task automatic send_item(input req_t item);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		due_responses.push_back(compute_response(item));
	endtask

	// Stop offering and wait until every response is in and the block is quiet.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (due_responses.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_POLICY) begin
			shadow_policy = data[POL_W-1:0];
		end else begin
			shadow_lfsr = (data == '0) ? LFSR_W'(1) : data;
		end
		@(posedge clk);
	endtask

	function automatic req_t make_cmd(input logic cmd, input logic [INST_W-1:0] inst,
		input logic [PRI_W-1:0] pri, input logic [TIME_W-1:0] issue,
		input logic [TIME_W-1:0] now);
		req_t r;
		r.cmd          = cmd;
		r.inst_id      = inst;
		r.priority_req = pri;
		r.issue_time   = issue;
		r.cur_time     = now;
		return r;
	endfunction

	// Mostly a running tick with plausible issue times; some fully random fields.
	function automatic req_t make_item(input int insert_pct);
		req_t r;
		r.cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_ARB;
		if ($urandom_range(3) == 0) begin
			r.inst_id      = INST_W'($urandom);
			r.priority_req = PRI_W'($urandom);
			r.issue_time   = $urandom;
			r.cur_time     = $urandom;
		end else begin
			sim_tick       = sim_tick + $urandom_range(0, 40);
			r.inst_id      = INST_W'($urandom);
			r.priority_req = $urandom_range(1) ? PRI_W'($urandom_range(0, 3))
				: PRI_W'($urandom);
			r.issue_time   = sim_tick - $urandom_range(0, 200);
			// Now and then a transfer stamped in the future, so the wait clamps.
			if ($urandom_range(9) == 0) begin
				r.issue_time = sim_tick + $urandom_range(1, 300);
			end
			r.cur_time     = sim_tick;
		end
		return r;
	endfunction

	// Empty arbitrate, extreme fields, fill to overflow, wait clamp and full wait.
	task automatic test_empty_and_full();
		int k;
		send_item(make_cmd(CMD_ARB, '0, '0, '0, '0));
		send_item(make_cmd(CMD_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_cmd(CMD_INSERT, 16'h0000, 8'h00, 32'h0000_0000, 32'h0000_0000));
		for (k = 2; k < QUEUE_DEPTH + 1; k++) begin
			send_item(make_cmd(CMD_INSERT, INST_W'($urandom),
				(k == 3 || k == 6) ? 8'hFF : PRI_W'($urandom_range(0, 100)),
				$urandom_range(1000, 5000), $urandom));
		end
		send_item(make_cmd(CMD_ARB, '0, '0, '0, 32'h0000_0000));
		send_item(make_cmd(CMD_ARB, '0, '0, '0, 32'hFFFF_FFFF));
	endtask

	// Grants under each remaining policy, priority ties and the zero seed.
	task automatic test_policy_picks();
		wait_idle();
		write_reg(CFG_POLICY, {14'h3FFF, POL_NEWEST});
		send_item(make_cmd(CMD_ARB, '0, '0, '0, 32'd6000));
		wait_idle();
		write_reg(CFG_POLICY, {14'h0000, POL_PRIORITY});
		send_item(make_cmd(CMD_ARB, '0, '0, '0, 32'd6000));
		send_item(make_cmd(CMD_ARB, '0, '0, '0, 32'd6000));
		wait_idle();
		write_reg(CFG_SEED, 16'h0000);
		write_reg(CFG_POLICY, {14'h1555, POL_RANDOM});
		send_item(make_cmd(CMD_ARB, '0, '0, '0, 32'd7000));
		send_item(make_cmd(CMD_ARB, '0, '0, '0, 32'd7000));
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		int k;
		wait_idle();
		write_reg(CFG_POLICY, {14'h0000, POL_OLDEST});
		send_idle_pct = 0;
		stall_pct     <= 0;
		hold_tog      <= ~hold_tog;
		sim_tick      = $urandom;
		for (k = 0; k < 60; k++) begin
			send_item(make_item(60));
		end
	endtask

	// The sender pauses mid-stream until every response has arrived.
	task automatic test_drain_pause();
		int k;
		for (k = 0; k < 20; k++) begin
			send_item(make_item(70));
		end
		wait_idle();
		for (k = 0; k < 20; k++) begin
			send_item(make_item(40));
		end
	endtask

	task automatic run_segment(input int idle_pct, input int stall, input logic [POL_W-1:0] pol,
		input logic [CFG_W-1:0] seed, input int n_items);
		logic [CFG_W-1:0] d;
		int               bias;
		int               k;
		wait_idle();
		write_reg(CFG_SEED, seed);
		d            = CFG_W'($urandom);
		d[POL_W-1:0] = pol;
		write_reg(CFG_POLICY, d);
		send_idle_pct = idle_pct;
		stall_pct     <= stall;
		sim_tick      = $urandom;
		bias          = 50;
		for (k = 0; k < n_items; k++) begin
			// Shift the insert mix now and then so the queue swings between full and empty.
			if (k % 25 == 0) begin
				case ($urandom_range(2))
					0:       bias = 85;
					1:       bias = 50;
					default: bias = 20;
				endcase
			end
			send_item(make_item(bias));
		end
	endtask

	// Every policy under each idling pattern, seeds at both ends and in between.
	task automatic test_random_phases();
		int               ph;
		int               p;
		int               idle_pct;
		int               stall;
		logic [CFG_W-1:0] seed;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin idle_pct = 0;  stall = 0;  end
				1:       begin idle_pct = 79; stall = 0;  end
				2:       begin idle_pct = 0;  stall = 79; end
				default: begin idle_pct = 19; stall = 19; end
			endcase
			for (p = 0; p < 4; p++) begin
				case (ph)
					0:       seed = 16'hFFFF;
					1:       seed = 16'h0001;
					default: seed = CFG_W'($urandom);
				endcase
				run_segment(idle_pct, stall, POL_W'(p), seed, 110);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_full();
		test_policy_picks();
		test_backpressure();
		test_drain_pause();
		test_random_phases();
		wait_idle();
		if (err_count == 0 && due_responses.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

### sim.f
rtl/tqpa_pkg.sv
rtl/tqpa_ctrl.sv
rtl/tqpa_datapath.sv
rtl/transfer_queue_policy_arbiter.sv
tb/tb.sv
